[rtl/core/mexp_pkg.sv]
package mexp_pkg;

    // Register index decode: two registers, one index bit
    localparam int unsigned REG_IDX_BITS = 1;
    localparam logic [REG_IDX_BITS-1:0] REG_MODULUS  = 1'b0;
    localparam logic [REG_IDX_BITS-1:0] REG_EXPONENT = 1'b1;

    // Status of the shared modular multiply unit
    typedef struct packed {
        logic busy;
        logic done;
    } mexp_unit_stat_t;

endpackage

[rtl/core/mexp_cfg.sv]
module mexp_cfg #(
    parameter int unsigned WORD_BITS  = 32,
    parameter int unsigned CFG_BITS   = 32,
    parameter int unsigned ADDR_LSB   = 2,
    parameter int unsigned PADDR_BITS = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [CFG_BITS-1:0]   pwdata,
    output logic [CFG_BITS-1:0]   prdata,
    output logic                  pready,
    output logic [WORD_BITS-1:0]  modulus,
    output logic [WORD_BITS-1:0]  exponent
);
    import mexp_pkg::*;

    logic [WORD_BITS-1:0]    modulus_reg;
    logic [WORD_BITS-1:0]    exponent_reg;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:ADDR_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= WORD_BITS'(1);
            exponent_reg <= WORD_BITS'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODULUS:  modulus_reg  <= pwdata[WORD_BITS-1:0];
                REG_EXPONENT: exponent_reg <= pwdata[WORD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Return the addressed register, zero extended
    always_comb
    begin
        unique case (reg_idx)
            REG_MODULUS:  prdata = CFG_BITS'(modulus_reg);
            REG_EXPONENT: prdata = CFG_BITS'(exponent_reg);
            default:      prdata = '0;
        endcase
    end

    assign modulus  = modulus_reg;
    assign exponent = exponent_reg;

endmodule

[rtl/core/mexp_mulmod.sv]
module mexp_mulmod #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [WORD_BITS-1:0]     mult,
    input  logic [WORD_BITS-1:0]     addend,
    input  logic [WORD_BITS-1:0]     modulus,
    output logic [WORD_BITS-1:0]     result,
    output mexp_pkg::mexp_unit_stat_t stat
);
    import mexp_pkg::*;

    localparam int unsigned CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] acc_next;
    logic [WORD_BITS-1:0] mult_reg;
    logic [WORD_BITS-1:0] addend_reg;

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+1:0] mod1;
    logic [WORD_BITS+1:0] mod2;
    logic [WORD_BITS+2:0] diff1;
    logic [WORD_BITS+2:0] diff2;
    logic                 mod_zero;

    // One shift-add step: acc = (2*acc + bit*addend) mod modulus
    assign mod_zero = (modulus == '0);
    assign sum   = {1'b0, acc_reg, 1'b0}
                 + {2'b00, (mult_reg[WORD_BITS-1] ? addend_reg : {WORD_BITS{1'b0}})};
    assign mod1  = {2'b00, modulus};
    assign mod2  = {1'b0, modulus, 1'b0};
    assign diff1 = {1'b0, sum} - {1'b0, mod1};
    assign diff2 = {1'b0, sum} - {1'b0, mod2};

    // Sum stays below three times the modulus: subtract once or twice
    always_comb
    begin
        priority if (mod_zero)
            acc_next = sum[WORD_BITS-1:0];
        else if (!diff2[WORD_BITS+2])
            acc_next = diff2[WORD_BITS-1:0];
        else if (!diff1[WORD_BITS+2])
            acc_next = diff1[WORD_BITS-1:0];
        else
            acc_next = sum[WORD_BITS-1:0];
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands, then walk multiplier bits from the top
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            acc_reg    <= '0;
            mult_reg   <= mult;
            addend_reg <= addend;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            mult_reg <= {mult_reg[WORD_BITS-2:0], 1'b0};
        end
    end

    assign result    = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/core/modular_exponentiation.sv]
// Modular exponentiation: power_value = message ** exponent mod modulus.
// Input channel in_valid/in_ready carries one message word; output channel
// out_valid/out_ready carries one power_value word per message.
// Modulus and exponent are set through the APB port (modulus at offset 0,
// exponent at the next register slot); the user must set them only while
// the block is idle, which the block itself does not enforce. One shared
// shift-add modular multiplier does all the work, one multiplier bit per
// cycle. A message is first reduced by the modulus (one multiply pass), then
// the exponent is scanned from its low bit: a multiply on each set bit and a
// square on each bit below the top set bit. An exponent of zero returns 1.
// in_ready is high only while the sequencer is idle, so one message is in
// work at a time. A finished word sits in the output register; a new
// message may be taken meanwhile, and its result waits until the receiver
// takes the old one. Reset clears both channels and sets modulus and
// exponent to 1.
module modular_exponentiation #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [((WORD_BITS > 32) ? 3 : 2)
                  + mexp_pkg::REG_IDX_BITS - 1:0]        paddr,
    input  logic [((WORD_BITS > 32) ? 64 : 32)-1:0]      pwdata,
    output logic [((WORD_BITS > 32) ? 64 : 32)-1:0]      prdata,
    output logic                                         pready,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [WORD_BITS-1:0]                         message,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [WORD_BITS-1:0]                         power_value
);
    import mexp_pkg::*;

    localparam int unsigned CFG_BITS   = (WORD_BITS > 32) ? 64 : 32;
    localparam int unsigned ADDR_LSB   = (WORD_BITS > 32) ? 3 : 2;
    localparam int unsigned PADDR_BITS = ADDR_LSB + REG_IDX_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_SQR    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [WORD_BITS-1:0] modulus;
    logic [WORD_BITS-1:0] exponent;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic                 start_reg;
    logic                 start_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_BITS-1:0] base_reg;
    logic [WORD_BITS-1:0] base_next;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] acc_next;
    logic [WORD_BITS-1:0] exp_reg;
    logic [WORD_BITS-1:0] exp_next;
    logic [WORD_BITS-1:0] out_reg;
    logic [WORD_BITS-1:0] out_next;

    logic [WORD_BITS-1:0] unit_mult;
    logic [WORD_BITS-1:0] unit_addend;
    logic [WORD_BITS-1:0] unit_result;
    mexp_unit_stat_t      unit_stat;

    logic                 in_fire;
    logic                 out_free;
    logic [WORD_BITS-1:0] exp_shift;

    mexp_cfg #(
        .WORD_BITS  (WORD_BITS),
        .CFG_BITS   (CFG_BITS),
        .ADDR_LSB   (ADDR_LSB),
        .PADDR_BITS (PADDR_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .modulus  (modulus),
        .exponent (exponent)
    );

    mexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .mult    (unit_mult),
        .addend  (unit_addend),
        .modulus (modulus),
        .result  (unit_result),
        .stat    (unit_stat)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign exp_shift   = {1'b0, exp_reg[WORD_BITS-1:1]};
    assign out_valid   = out_valid_reg;
    assign power_value = out_reg;

    // Select unit operands for the pass being started
    always_comb
    begin
        unique case (state_reg)
            S_REDUCE:
            begin
                unit_mult   = base_reg;
                unit_addend = WORD_BITS'(1);
            end
            S_MUL:
            begin
                unit_mult   = acc_reg;
                unit_addend = base_reg;
            end
            default:
            begin
                unit_mult   = base_reg;
                unit_addend = base_reg;
            end
        endcase
    end

    // Sequence reduce, multiply and square passes over the exponent bits
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        exp_next       = exp_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    base_next = message;
                    exp_next  = exponent;
                    acc_next  = WORD_BITS'(1);
                    if (exponent == '0)
                        state_next = S_OUT;
                    else
                    begin
                        state_next = S_REDUCE;
                        start_next = 1'b1;
                    end
                end
            end
            S_REDUCE:
            begin
                if (unit_stat.done)
                begin
                    base_next  = unit_result;
                    start_next = 1'b1;
                    state_next = exp_reg[0] ? S_MUL : S_SQR;
                end
            end
            S_MUL:
            begin
                if (unit_stat.done)
                begin
                    acc_next = unit_result;
                    if (exp_shift == '0)
                        state_next = S_OUT;
                    else
                    begin
                        state_next = S_SQR;
                        start_next = 1'b1;
                    end
                end
            end
            S_SQR:
            begin
                if (unit_stat.done)
                begin
                    base_next  = unit_result;
                    exp_next   = exp_shift;
                    start_next = 1'b1;
                    state_next = exp_shift[0] ? S_MUL : S_SQR;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working words
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        exp_reg  <= exp_next;
        out_reg  <= out_next;
    end

    // Never launch a pass while the unit is still stepping
    assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !unit_stat.busy)
    else $error("multiply unit started while busy");

    // A finished pass only lands in a compute state
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_stat.done |-> (state_reg == S_REDUCE || state_reg == S_MUL
                            || state_reg == S_SQR))
    else $error("multiply unit done outside a compute state");

    // Exponent zero goes straight to the output with a result of one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && exponent == '0) |=> (state_reg == S_OUT && acc_reg == WORD_BITS'(1)))
    else $error("zero exponent did not yield one");

    // Remaining exponent never runs out while computing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE || state_reg == S_MUL || state_reg == S_SQR)
        |-> (exp_reg != '0))
    else $error("exponent exhausted during compute");

endmodule
